// File: sv/rotenc_pkg.sv
package rotenc_pkg;

	// Default number of encoders handled by one block.
	localparam int NUM_ENCODERS_DEF = 16;

	// Configuration register indexes.
	localparam logic CFG_DEBOUNCE_TIME = 1'b0;
	localparam logic CFG_PRESS_TIME    = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd10;
	localparam logic [15:0] PRESS_TIME_RST    = 16'd50;

	// Step modes.
	localparam logic [1:0] MODE_FULL    = 2'd0;
	localparam logic [1:0] MODE_HALF    = 2'd1;
	localparam logic [1:0] MODE_QUARTER = 2'd2;

	// Direction codes as reported and latched.
	localparam logic [1:0] EVT_NONE = 2'd0;
	localparam logic [1:0] EVT_CW   = 2'd1;
	localparam logic [1:0] EVT_CCW  = 2'd2;

	// Direction flags inside a table entry.
	localparam logic [5:0] DIR_CW  = 6'h10;
	localparam logic [5:0] DIR_CCW = 6'h20;

	localparam logic [5:0] FULL_TAB [7][4] = '{
		'{6'h0, 6'h5, 6'h2, 6'h0},
		'{DIR_CW, 6'h1, 6'h1, 6'h1},
		'{6'h0, 6'h2, 6'h2, 6'h3},
		'{6'h0, 6'h1, 6'h3, 6'h3},
		'{6'h0, 6'h4, 6'h6, 6'h4},
		'{6'h0, 6'h5, 6'h5, 6'h4},
		'{DIR_CCW, 6'h6, 6'h6, 6'h6}
	};

	localparam logic [5:0] HALF_TAB [6][4] = '{
		'{6'h0, 6'h4, 6'h2, 6'h3},
		'{DIR_CW, 6'h1, 6'h1, 6'h1},
		'{6'h2, 6'h2, 6'h2, 6'h3 | DIR_CW},
		'{6'h0, 6'h1, 6'h5, 6'h3},
		'{6'h4, 6'h4, 6'h4, 6'h3 | DIR_CCW},
		'{DIR_CCW, 6'h5, 6'h5, 6'h5}
	};

	localparam logic [5:0] QUART_TAB [4][4] = '{
		'{6'h0, 6'h1 | DIR_CCW, 6'h2 | DIR_CW, 6'h3},
		'{DIR_CW, 6'h1, 6'h1, 6'h3 | DIR_CCW},
		'{DIR_CCW, 6'h2, 6'h2, 6'h3 | DIR_CW},
		'{6'h0, 6'h1 | DIR_CW, 6'h2 | DIR_CCW, 6'h3}
	};

	typedef struct packed {
		logic [3:0]  encoder_index;
		logic [1:0]  step_mode;
		logic        pin_a;
		logic        pin_b;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [3:0] encoder_number;
		logic [1:0] direction_event;
		logic       cw_button;
		logic       ccw_button;
	} out_item_t;

	// Next table state. A row beyond the selected table reads as row 0;
	// the unused step mode keeps the current state.
	function automatic logic [5:0] next_state(input logic [5:0] cur, input logic [1:0] mode,
		input logic [1:0] col);
		logic [3:0] row;
		logic [5:0] res;
		row = cur[3:0];
		unique case (mode)
			MODE_FULL:    res = FULL_TAB[(row < 4'd7) ? row[2:0] : 3'd0][col];
			MODE_HALF:    res = HALF_TAB[(row < 4'd6) ? row[2:0] : 3'd0][col];
			MODE_QUARTER: res = QUART_TAB[(row < 4'd4) ? row[1:0] : 2'd0][col];
			default:      res = cur;
		endcase
		return res;
	endfunction

endpackage

// File: sv/rotary_encoder_step_decoder_top.sv
// A result passes through the input register and then the result register.
// Throughput: one transaction per cycle while the output is not stalled, also
// for the same encoder back to back, since the per-encoder state is updated at
// the same edge that loads the result.
// Reset (arst_n low, asynchronous): all per-encoder state clears to zero,
// debounce_time returns to 10 ms and press_time to 50 ms, both pipeline stages empty.
module rotary_encoder_step_decoder_top
	import rotenc_pkg::*;
#(
	parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	// Width of an index into the per-encoder state.
	localparam int IdxW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

	// Configuration registers.
	logic [15:0] debounce_time_q;
	logic [15:0] press_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q <= DEBOUNCE_TIME_RST;
			press_time_q    <= PRESS_TIME_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DEBOUNCE_TIME: debounce_time_q <= cfg_data;
				CFG_PRESS_TIME:    press_time_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Input register. The stage advances whenever it is empty, the result
	// register is empty or its transaction completes this cycle, so a new input
	// is taken even while a finished result waits on the output.
	logic     valid_s1;
	in_item_t data_s1;
	logic     adv_s1;
	logic     in_take;

	assign adv_s1   = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= in_data;
		end
	end

	// Per-encoder state, one register set per encoder, read at the index of
	// the item in the input register.
	logic [5:0]  table_state_q       [NUM_ENCODERS];
	logic [1:0]  latched_direction_q [NUM_ENCODERS];
	logic [31:0] last_event_time_q   [NUM_ENCODERS];
	logic [1:0]  shown_direction_q   [NUM_ENCODERS];
	logic        cw_pressed_q        [NUM_ENCODERS];
	logic        ccw_pressed_q       [NUM_ENCODERS];

	logic [IdxW-1:0] sel;
	logic            in_range;
	logic [5:0]      new_state;
	logic [1:0]      dir;
	logic [31:0]     elapsed;
	logic            latch_now;
	logic            expired;
	logic [1:0]      latched_nx;
	logic [1:0]      shown_nx;
	logic            cw_nx;
	logic            ccw_nx;

	always_comb begin
		sel       = IdxW'(data_s1.encoder_index);
		in_range  = 32'(data_s1.encoder_index) < 32'(NUM_ENCODERS);
		new_state = next_state(table_state_q[sel], data_s1.step_mode,
			{data_s1.pin_a, data_s1.pin_b});
		dir       = new_state[5:4];
		elapsed   = data_s1.now_ms - last_event_time_q[sel];
		// A direction event latches only once the debounce window has passed.
		latch_now = (dir != EVT_NONE) && (elapsed > 32'(debounce_time_q));
		// A fresh latch restarts the time base at zero elapsed, which never
		// exceeds the press time, so only the old elapsed time can expire.
		expired    = !latch_now && (elapsed > 32'(press_time_q));
		latched_nx = latch_now ? dir : latched_direction_q[sel];
		shown_nx   = shown_direction_q[sel];
		cw_nx      = cw_pressed_q[sel];
		ccw_nx     = ccw_pressed_q[sel];
		if (expired) begin
			latched_nx = EVT_NONE;
			shown_nx   = EVT_NONE;
			cw_nx      = 1'b0;
			ccw_nx     = 1'b0;
		end else if (shown_direction_q[sel] == EVT_NONE) begin
			// The first latched direction presses its button and holds it.
			if (latched_nx == EVT_CW) begin
				cw_nx = 1'b1;
			end
			if (latched_nx == EVT_CCW) begin
				ccw_nx = 1'b1;
			end
			shown_nx = latched_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ENCODERS; k++) begin
				table_state_q[k]       <= '0;
				latched_direction_q[k] <= '0;
				last_event_time_q[k]   <= '0;
				shown_direction_q[k]   <= '0;
				cw_pressed_q[k]        <= 1'b0;
				ccw_pressed_q[k]       <= 1'b0;
			end
		end else if (valid_s1 && adv_s1 && in_range) begin
			table_state_q[sel]       <= new_state;
			latched_direction_q[sel] <= latched_nx;
			shown_direction_q[sel]   <= shown_nx;
			cw_pressed_q[sel]        <= cw_nx;
			ccw_pressed_q[sel]       <= ccw_nx;
			if (latch_now) begin
				last_event_time_q[sel] <= data_s1.now_ms;
			end
		end
	end

	// Result register. An index beyond the encoder count reports no event
	// and both buttons released.
	logic      out_valid_q;
	out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			out_data_q.encoder_number  <= data_s1.encoder_index;
			out_data_q.direction_event <= in_range ? dir : EVT_NONE;
			out_data_q.cw_button       <= in_range && cw_nx;
			out_data_q.ccw_button      <= in_range && ccw_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The input side only stalls when the input register holds an item.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// An item leaving the input register lands in the result register.
	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> out_valid)
		else $error("item lost between input and result register");

	// Only one virtual button can be pressed at a time.
	a_one_button: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.cw_button && out_data.ccw_button))
		else $error("both buttons pressed");

	// An encoder index beyond the encoder count gives an empty result.
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (32'(out_data.encoder_number) >= 32'(NUM_ENCODERS)))
		|-> (out_data.direction_event == EVT_NONE && !out_data.cw_button
		&& !out_data.ccw_button))
		else $error("result for a missing encoder is not empty");

endmodule

// File: verif/rotenc_decode_checker.sv
module rotenc_decode_checker
	import rotenc_pkg::*;
#(
	parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [5:0] FULL_STEPS [7][4] = '{
		'{6'h0, 6'h5, 6'h2, 6'h0},
		'{DIR_CW, 6'h1, 6'h1, 6'h1},
		'{6'h0, 6'h2, 6'h2, 6'h3},
		'{6'h0, 6'h1, 6'h3, 6'h3},
		'{6'h0, 6'h4, 6'h6, 6'h4},
		'{6'h0, 6'h5, 6'h5, 6'h4},
		'{DIR_CCW, 6'h6, 6'h6, 6'h6}
	};

	localparam logic [5:0] HALF_STEPS [6][4] = '{
		'{6'h0, 6'h4, 6'h2, 6'h3},
		'{DIR_CW, 6'h1, 6'h1, 6'h1},
		'{6'h2, 6'h2, 6'h2, 6'h3 | DIR_CW},
		'{6'h0, 6'h1, 6'h5, 6'h3},
		'{6'h4, 6'h4, 6'h4, 6'h3 | DIR_CCW},
		'{DIR_CCW, 6'h5, 6'h5, 6'h5}
	};

	localparam logic [5:0] QUARTER_STEPS [4][4] = '{
		'{6'h0, 6'h1 | DIR_CCW, 6'h2 | DIR_CW, 6'h3},
		'{DIR_CW, 6'h1, 6'h1, 6'h3 | DIR_CCW},
		'{DIR_CCW, 6'h2, 6'h2, 6'h3 | DIR_CW},
		'{6'h0, 6'h1 | DIR_CW, 6'h2 | DIR_CCW, 6'h3}
	};

	logic [15:0] debounce_ms;
	logic [15:0] press_ms;
	logic [5:0]  row_state [NUM_ENCODERS];
	logic [1:0]  latched [NUM_ENCODERS];
	logic [31:0] event_ms [NUM_ENCODERS];
	logic [1:0]  shown [NUM_ENCODERS];
	logic        cw_held [NUM_ENCODERS];
	logic        ccw_held [NUM_ENCODERS];

	out_item_t expected_reports [$];
	out_item_t want;

	task automatic flag_mismatch(input string what);
		if (errors < 40)
			$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	// Advances one encoder by one pin sample and returns the report it should give.
	function automatic out_item_t decode_sample(input in_item_t s);
		out_item_t   r;
		int          e;
		logic [1:0]  col;
		logic [3:0]  row;
		logic [5:0]  nxt;
		logic [1:0]  dir;
		logic [31:0] age;
		e = s.encoder_index;
		r.encoder_number = s.encoder_index;
		if (e >= NUM_ENCODERS) begin
			r.direction_event = EVT_NONE;
			r.cw_button = 1'b0;
			r.ccw_button = 1'b0;
			return r;
		end
		col = {s.pin_a, s.pin_b};
		row = row_state[e][3:0];
		case (s.step_mode)
			MODE_FULL:    nxt = FULL_STEPS[(row < 4'd7) ? row[2:0] : 3'd0][col];
			MODE_HALF:    nxt = HALF_STEPS[(row < 4'd6) ? row[2:0] : 3'd0][col];
			MODE_QUARTER: nxt = QUARTER_STEPS[(row < 4'd4) ? row[1:0] : 2'd0][col];
			default:      nxt = row_state[e];
		endcase
		row_state[e] = nxt;
		dir = nxt[5:4];
		age = s.now_ms - event_ms[e];
		if (dir != EVT_NONE && age > {16'd0, debounce_ms}) begin
			latched[e] = dir;
			event_ms[e] = s.now_ms;
		end
		age = s.now_ms - event_ms[e];
		if (age > {16'd0, press_ms}) begin
			cw_held[e] = 1'b0;
			ccw_held[e] = 1'b0;
			latched[e] = EVT_NONE;
			shown[e] = EVT_NONE;
		end else if (shown[e] == EVT_NONE) begin
			if (latched[e] == EVT_CW)
				cw_held[e] = 1'b1;
			if (latched[e] == EVT_CCW)
				ccw_held[e] = 1'b1;
			shown[e] = latched[e];
		end
		r.direction_event = dir;
		r.cw_button = cw_held[e];
		r.ccw_button = ccw_held[e];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms = DEBOUNCE_TIME_RST;
			press_ms = PRESS_TIME_RST;
			for (int k = 0; k < NUM_ENCODERS; k++) begin
				row_state[k] = '0;
				latched[k] = EVT_NONE;
				event_ms[k] = '0;
				shown[k] = EVT_NONE;
				cw_held[k] = 1'b0;
				ccw_held[k] = 1'b0;
			end
			expected_reports.delete();
			errors = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_DEBOUNCE_TIME: debounce_ms = cfg_data;
					CFG_PRESS_TIME:    press_ms = cfg_data;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					flag_mismatch($sformatf("result for encoder %0d with none expected",
						out_data.encoder_number));
				end else begin
					want = expected_reports.pop_front();
					if (out_data.encoder_number !== want.encoder_number)
						flag_mismatch($sformatf("encoder_number %0d, expected %0d",
							out_data.encoder_number, want.encoder_number));
					if (out_data.direction_event !== want.direction_event)
						flag_mismatch($sformatf("enc %0d direction_event %0d, expected %0d",
							want.encoder_number, out_data.direction_event,
							want.direction_event));
					if (out_data.cw_button !== want.cw_button)
						flag_mismatch($sformatf("enc %0d cw_button %0b, expected %0b",
							want.encoder_number, out_data.cw_button, want.cw_button));
					if (out_data.ccw_button !== want.ccw_button)
						flag_mismatch($sformatf("enc %0d ccw_button %0b, expected %0b",
							want.encoder_number, out_data.ccw_button, want.ccw_button));
				end
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(decode_sample(in_data));
		end
		pending = expected_reports.size();
	end

endmodule

// File: verif/tb_top.sv
module tb_top;
	import rotenc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ENC      = NUM_ENCODERS_DEF;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1150;
	localparam int PHASES       = 7;
	localparam int HOLD_CYCLES  = 300;

	// The fourth step mode selects no table; the block just repeats the state.
	localparam logic [1:0] MODE_HOLD = 2'd3;

	// Pin levels A,B as a two-bit column, walked in quadrature order.
	localparam logic [1:0] GRAY_SEQ [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

	// Timing settings for the phases after the first, which keeps the reset values.
	// The last entry is replaced by a random pair at run time.
	localparam logic [15:0] DEB_SET [PHASES-1] = '{16'd0, 16'd65535, 16'd0, 16'd65535,
		16'd3, 16'd5};
	localparam logic [15:0] PRESS_SET [PHASES-1] = '{16'd0, 16'd65535, 16'd65535, 16'd0,
		16'd20, 16'd12};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = CFG_DEBOUNCE_TIME;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;

	int          mismatch_count;
	int          pending_results;

	// Stimulus bookkeeping.
	logic [31:0] clock_ms = '0;
	logic [15:0] cur_debounce = DEBOUNCE_TIME_RST;
	logic [15:0] cur_press = PRESS_TIME_RST;
	int          sent = 0;
	int          cycle_count = 0;
	int          walk_pos [NUM_ENC];
	bit          no_idle = 1'b0;
	bit          long_hold = 1'b0;
	int          stall_left = 0;
	int          run_left = 0;
	bit          stall_now = 1'b0;

	rotary_encoder_step_decoder_top #(
		.NUM_ENCODERS(NUM_ENC)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// The checker sees both channels and the register port, predicts every result
	// and hands back its mismatch count and the number of results still owed.
	rotenc_decode_checker #(
		.NUM_ENCODERS(NUM_ENC)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.errors    (mismatch_count),
		.pending   (pending_results)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Length of an idle or busy stretch: mostly short, now and then long.
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(3, 1);
		else if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// Gap before the next input transaction. Bursts flagged no_idle go back to back.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// A step mode, with the table-less mode coming up only rarely.
	function automatic logic [1:0] pick_mode();
		if ($urandom_range(99) < 6)
			return MODE_HOLD;
		return 2'($urandom_range(2));
	endfunction

	// Time steps scale with the active settings so that every phase crosses
	// both the debounce window and the press time.
	function automatic int timing_scale();
		return ((cur_debounce > cur_press) ? int'(cur_debounce) : int'(cur_press)) + 8;
	endfunction

	// Receiver: random stall stretches, plus the long hold-off when it is on.
	// Busy stretches drawn here also give periods with no stall at all.
	always @(negedge clk) begin
		if (run_left > 0) begin
			run_left--;
			stall_now = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			stall_now = 1'b1;
		end else if ($urandom_range(3) == 0) begin
			stall_left = pick_len() - 1;
			stall_now = 1'b1;
		end else begin
			run_left = pick_len() - 1;
			stall_now = 1'b0;
		end
		out_stall <= long_hold || stall_now;
	end

	// Long hold-off on the output side, timed in cycles on its own. The sender
	// keeps offering samples, so the pipeline fills and the input stalls.
	initial begin
		do @(negedge clk); while (sent < 400);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		long_hold <= 1'b0;
	end

	// Offers one sample transaction and returns at the falling edge after it
	// was taken. Valid stays high when the next call has no gap.
	task automatic send_sample(input int e, input logic [1:0] mode, input logic [1:0] col,
		input logic [31:0] t);
		in_item_t it;
		int       gap;
		it.encoder_index = e[3:0];
		it.step_mode = mode;
		it.pin_a = col[1];
		it.pin_b = col[0];
		it.now_ms = t;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	// Drops valid and waits until the checker has seen every owed result.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// Registers change only with the block empty; the short pause covers the
	// two pipeline stages.
	task automatic set_timing(input logic [15:0] deb, input logic [15:0] prs);
		wait_drain();
		repeat (4) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DEBOUNCE_TIME;
		cfg_data <= deb;
		@(negedge clk);
		cfg_index <= CFG_PRESS_TIME;
		cfg_data <= prs;
		@(negedge clk);
		cfg_write <= 1'b0;
		cur_debounce = deb;
		cur_press = prs;
	endtask

	// Moves the millisecond clock: mostly small steps, sometimes past the
	// windows, rarely a jump to anywhere in the 32-bit range.
	task automatic advance_ms();
		int r;
		int scale;
		scale = timing_scale();
		r = $urandom_range(99);
		if (r < 55)
			clock_ms += $urandom_range(3);
		else if (r < 85)
			clock_ms += $urandom_range(scale / 2);
		else if (r < 97)
			clock_ms += $urandom_range(scale * 2, scale / 2);
		else
			clock_ms = $urandom;
	endtask

	// One quadrature step of an encoder in the given direction.
	task automatic step_walk(input int e, input logic [1:0] mode, input int dir);
		walk_pos[e] = (walk_pos[e] + dir + 4) % 4;
		send_sample(e, mode, GRAY_SEQ[walk_pos[e]], clock_ms);
	endtask

	// One burst of random stimulus. Most bursts turn a knob through several
	// detents with occasional contact bounce; the rest are noise, broken pin
	// sequences, and quiet periods that should release held buttons.
	task automatic run_burst();
		int         kind;
		int         e;
		int         dir;
		int         len;
		logic [1:0] mode;
		kind = $urandom_range(99);
		e = $urandom_range(NUM_ENC - 1);
		mode = pick_mode();
		no_idle = ($urandom_range(9) == 0);
		if (kind < 70) begin
			dir = ($urandom_range(1) == 1) ? 1 : -1;
			len = $urandom_range(12, 4);
			repeat (len) begin
				advance_ms();
				step_walk(e, mode, ($urandom_range(9) == 0) ? -dir : dir);
			end
		end else if (kind < 85) begin
			send_sample($urandom_range(NUM_ENC - 1), 2'($urandom_range(3)),
				2'($urandom_range(3)), ($urandom_range(1) == 1) ? $urandom : clock_ms);
		end else if (kind < 93) begin
			repeat ($urandom_range(6, 3)) begin
				advance_ms();
				send_sample(e, mode, 2'($urandom_range(3)), clock_ms);
			end
		end else begin
			clock_ms += timing_scale() * 2 + $urandom_range(timing_scale());
			repeat ($urandom_range(4, 1)) begin
				e = $urandom_range(NUM_ENC - 1);
				send_sample(e, pick_mode(), GRAY_SEQ[walk_pos[e]], clock_ms);
			end
		end
	endtask

	initial begin
		int          phase_start;
		logic [15:0] deb;
		logic [15:0] prs;
		foreach (walk_pos[k])
			walk_pos[k] = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the reset timing of 10 ms debounce and 50 ms press.
		// Full-step detent clockwise on encoder 0, then a quiet sample that
		// comes after the press time and releases the button.
		send_sample(0, MODE_FULL, 2'd2, 32'd100);
		send_sample(0, MODE_FULL, 2'd3, 32'd101);
		send_sample(0, MODE_FULL, 2'd1, 32'd102);
		send_sample(0, MODE_FULL, 2'd0, 32'd103);
		send_sample(0, MODE_FULL, 2'd0, 32'd200);
		// Counter-clockwise on encoder 1, then a second detent inside the
		// debounce window that must not latch.
		send_sample(1, MODE_FULL, 2'd1, 32'd300);
		send_sample(1, MODE_FULL, 2'd3, 32'd301);
		send_sample(1, MODE_FULL, 2'd2, 32'd302);
		send_sample(1, MODE_FULL, 2'd0, 32'd303);
		send_sample(1, MODE_FULL, 2'd1, 32'd305);
		send_sample(1, MODE_FULL, 2'd3, 32'd306);
		send_sample(1, MODE_FULL, 2'd2, 32'd307);
		send_sample(1, MODE_FULL, 2'd0, 32'd308);
		// Half-step event at the mid position.
		send_sample(2, MODE_HALF, 2'd2, 32'd400);
		send_sample(2, MODE_HALF, 2'd3, 32'd401);
		// Quarter-step events, then the table-less mode repeating the flags.
		send_sample(3, MODE_QUARTER, 2'd1, 32'd500);
		send_sample(3, MODE_QUARTER, 2'd3, 32'd501);
		send_sample(3, MODE_HOLD, 2'd0, 32'd502);
		// A full-step row that the half-step table does not have reads as row 0.
		send_sample(4, MODE_FULL, 2'd1, 32'd600);
		send_sample(4, MODE_FULL, 2'd3, 32'd601);
		send_sample(4, MODE_FULL, 2'd2, 32'd602);
		send_sample(4, MODE_HALF, 2'd0, 32'd603);
		// The same for the quarter-step table.
		send_sample(5, MODE_FULL, 2'd1, 32'd610);
		send_sample(5, MODE_FULL, 2'd3, 32'd611);
		send_sample(5, MODE_QUARTER, 2'd2, 32'd612);
		// Highest encoder, with the millisecond counter wrapping through zero.
		send_sample(15, MODE_QUARTER, 2'd2, 32'hFFFF_FFF8);
		send_sample(15, MODE_QUARTER, 2'd3, 32'h0000_0002);
		clock_ms = 32'd1000;

		// Random phases, each under its own timing setting.
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				deb = DEB_SET[(p - 1) % (PHASES - 1)];
				prs = PRESS_SET[(p - 1) % (PHASES - 1)];
				if (p == PHASES - 1) begin
					deb = 16'($urandom_range(40));
					prs = 16'($urandom_range(120));
				end
				set_timing(deb, prs);
			end
			// In about half the phases, start just short of the wrap so the counter rolls over.
			if ($urandom_range(1) == 1)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(timing_scale() * 2);
			phase_start = sent;
			while (sent - phase_start < RANDOM_ITEMS / PHASES)
				run_burst();
		end

		wait_drain();
		repeat (8) @(negedge clk);
		$display("Covered %0d samples over %0d timing settings: detents in all step modes,",
			sent, PHASES);
		$display("bounce, row fallback, counter wrap and a long output hold-off.");
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
